@@ sv/assert_macros.svh @@
// Assertion macros for the clock RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is held.
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, off while reset is held.
`define ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ sv/tdcss_pkg.sv @@
// Shared types, constants and functions for the serial-set time-of-day clock.
package tdcss_pkg;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_QUERY = 8'h68;
    localparam logic [7:0] CH_ACK   = 8'h61;
    localparam logic [7:0] CH_ZERO  = 8'h30;

    localparam logic signed [8:0] MIN_PER_HOUR = 9'sd60;
    localparam logic signed [8:0] HOUR_PER_DAY = 9'sd24;

    // Command queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

    // Longest decimal text of one value (negative values print ten digits)
    localparam logic [3:0] NEG_TEXT_LEN = 4'd10;

    typedef enum logic {
        OP_TICK = 1'b0,
        OP_BYTE = 1'b1
    } opcode_t;

    // One unit of work for the back end
    typedef struct packed {
        logic       tick;
        logic       query;
        logic       load;
        logic [7:0] hour_load;
        logic [7:0] min_load;
    } cmd_t;

    // Decimal text of one time value: digit count and the low three digits
    typedef struct packed {
        logic [3:0] cnt;
        logic [3:0] d2;
        logic [3:0] d1;
        logic [3:0] d0;
    } digits_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_HOUR,
        B_COLON,
        B_MIN,
        B_ACK
    } back_state_t;

    // Two ASCII digits to a value, kept modulo 256
    function automatic logic [7:0] digit_pair(logic [7:0] tens, logic [7:0] units);
        logic [7:0] t;
        logic [7:0] u;
        t = tens - CH_ZERO;
        u = units - CH_ZERO;
        digit_pair = {t[4:0], 3'b000} + {t[6:0], 1'b0} + u;
    endfunction

    // Split a signed 8-bit value, printed as 32-bit unsigned, into its text.
    // A negative value prints as "4294967" followed by three digits of 168..295.
    function automatic digits_t value_digits(logic [7:0] v);
        digits_t     dg;
        logic [8:0]  n9;
        logic [1:0]  hund;
        logic [6:0]  rem7;
        logic [14:0] prod;
        logic [3:0]  tens;
        n9 = v[7] ? (9'd168 + {2'b00, v[6:0]}) : {1'b0, v};
        if (n9 >= 9'd200) begin
            hund = 2'd2;
            rem7 = 7'(n9 - 9'd200);
        end else if (n9 >= 9'd100) begin
            hund = 2'd1;
            rem7 = 7'(n9 - 9'd100);
        end else begin
            hund = 2'd0;
            rem7 = n9[6:0];
        end
        // rem7 / 10 by reciprocal, exact below 1029
        prod = {8'b0, rem7} * 15'd205;
        tens = prod[14:11];
        dg.d2 = {2'b00, hund};
        dg.d1 = tens;
        dg.d0 = 4'(rem7 - {3'b000, tens} * 7'd10);
        if (v[7]) begin
            dg.cnt = NEG_TEXT_LEN;
        end else if (hund != 2'd0) begin
            dg.cnt = 4'd3;
        end else if (tens != 4'd0) begin
            dg.cnt = 4'd2;
        end else begin
            dg.cnt = 4'd1;
        end
        value_digits = dg;
    endfunction

    // Character at position pos counted from the end of the text (0 = last)
    function automatic logic [7:0] pos_char(logic [3:0] pos, digits_t dg);
        logic [7:0] c;
        case (pos)
            4'd0:    c = CH_ZERO | {4'b0000, dg.d0};
            4'd1:    c = CH_ZERO | {4'b0000, dg.d1};
            4'd2:    c = CH_ZERO | {4'b0000, dg.d2};
            4'd3:    c = CH_ZERO | 8'd7;
            4'd4:    c = CH_ZERO | 8'd6;
            4'd5:    c = CH_ZERO | 8'd9;
            4'd6:    c = CH_ZERO | 8'd4;
            4'd7:    c = CH_ZERO | 8'd9;
            4'd8:    c = CH_ZERO | 8'd2;
            4'd9:    c = CH_ZERO | 8'd4;
            default: c = CH_ZERO;
        endcase
        pos_char = c;
    endfunction

endpackage

@@ sv/time_of_day_clock_serial_set.sv @@
// Top level of the hour:minute clock with serial set and query.
//
//  Channel | Direction | tdata          | tuser     | tlast
//  s_      | in        | [7:0] rx_byte  | [0] opcode| -
//  m_      | out       | [7:0] out_byte | -         | last
//
// A word that forms a command enters the command queue; the back end pops one command
// per cycle when idle and then sends one text word per cycle while m_tready is high.
// A tick updates the time with no output; a query sends the hour text, a colon and the minute text.
// Synchronous active-low reset clears time, byte history, queue and output.
// s_tready drops only while the two-entry command queue is full; output stalls
// hold the back end, and new input words are taken until the queue fills.
module time_of_day_clock_serial_set (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] rx_byte
    input  logic       s_tuser,   // [0] opcode
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast
);
    import tdcss_pkg::*;

    cmd_t push_cmd;
    cmd_t head_cmd;
    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_valid;

    tdcss_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (push_cmd)
    );

    tdcss_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_cmd   (head_cmd)
    );

    tdcss_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_cmd    (head_cmd),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

@@ sv/tdcss_front.sv @@
// Front end: take input words, keep the byte history and classify into commands.
module tdcss_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // [7:0] rx_byte
    input  logic                s_tuser,   // [0] opcode
    input  logic                q_full,
    output logic                q_push,
    output tdcss_pkg::cmd_t     q_cmd
);
    import tdcss_pkg::*;

    logic [7:0] hist_reg  [4];
    logic [7:0] hist_next [4];
    logic       accept;
    logic       is_query;
    logic       is_load;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    // Classify the word against the history window
    always_comb begin
        is_query = (s_tdata == CH_QUERY);
        is_load  = (hist_reg[1] == CH_COLON);
        q_cmd.tick      = (s_tuser == OP_TICK);
        q_cmd.query     = (s_tuser == OP_BYTE) && is_query;
        q_cmd.load      = (s_tuser == OP_BYTE) && is_load;
        q_cmd.hour_load = digit_pair(hist_reg[3], hist_reg[2]);
        q_cmd.min_load  = digit_pair(hist_reg[0], s_tdata);
        // Drop bytes that neither query nor load
        q_push = accept && (q_cmd.tick || q_cmd.query || q_cmd.load);
    end

    // Shift received bytes into the history
    always_comb begin
        hist_next = hist_reg;
        if (accept && s_tuser == OP_BYTE) begin
            hist_next[0] = s_tdata;
            hist_next[1] = hist_reg[0];
            hist_next[2] = hist_reg[1];
            hist_next[3] = hist_reg[2];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) begin
                hist_reg[i] <= 8'h00;
            end
        end else begin
            hist_reg <= hist_next;
        end
    end

endmodule

@@ sv/tdcss_fifo.sv @@
// Short command queue between the front and back ends.
module tdcss_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  tdcss_pkg::cmd_t push_cmd,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output tdcss_pkg::cmd_t head_cmd
);
    import tdcss_pkg::*;

    cmd_t              entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg;
    logic [QCNT_W-1:0] cnt_next;
    logic              do_pop;

    assign full       = (cnt_reg == QCNT_W'(QDEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    // Advance pointers and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store pushed commands
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

@@ sv/tdcss_back.sv @@
// Back end: run commands, keep the time and send the text words.
module tdcss_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            q_valid,
    input  tdcss_pkg::cmd_t q_cmd,
    output logic            q_pop,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [7:0]      m_tdata,   // [7:0] out_byte
    output logic            m_tlast
);
    import tdcss_pkg::*;

    `include "assert_macros.svh"

    back_state_t       state_reg;
    back_state_t       state_next;
    cmd_t              cmd_reg;
    digits_t           digs_reg;
    logic [3:0]        rem_cnt_reg;
    logic [7:0]        hour_reg;
    logic [7:0]        min_reg;
    logic              m_tvalid_reg;
    logic [7:0]        m_tdata_reg;
    logic              m_tlast_reg;
    logic              out_free;
    logic              emit;
    logic [7:0]        emit_char;
    logic              emit_last;
    logic signed [8:0] min_inc;
    logic signed [8:0] hour_inc;
    logic [7:0]        tick_min;
    logic [7:0]        tick_hour;
    digits_t           hour_digs;
    digits_t           min_digs;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    assign hour_digs = value_digits(hour_reg);
    assign min_digs  = value_digits(min_reg);

    // Advance the time by one minute
    always_comb begin
        min_inc  = {min_reg[7], min_reg} + 9'sd1;
        hour_inc = {hour_reg[7], hour_reg};
        if (min_inc >= MIN_PER_HOUR) begin
            min_inc  = 9'sd0;
            hour_inc = hour_inc + 9'sd1;
        end
        if (hour_inc >= HOUR_PER_DAY) begin
            hour_inc = 9'sd0;
        end
        tick_min  = min_inc[7:0];
        tick_hour = hour_inc[7:0];
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE: begin
                if (q_valid) begin
                    if (q_cmd.tick) begin
                        state_next = B_IDLE;
                    end else if (q_cmd.query) begin
                        state_next = B_HOUR;
                    end else begin
                        state_next = B_ACK;
                    end
                end
            end
            B_HOUR: begin
                if (emit && rem_cnt_reg == 4'd1) begin
                    state_next = B_COLON;
                end
            end
            B_COLON: begin
                if (emit) begin
                    state_next = B_MIN;
                end
            end
            B_MIN: begin
                if (emit && rem_cnt_reg == 4'd1) begin
                    state_next = cmd_reg.load ? B_ACK : B_IDLE;
                end
            end
            B_ACK: begin
                if (emit) begin
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        q_pop     = 1'b0;
        emit      = 1'b0;
        emit_char = CH_ACK;
        emit_last = 1'b0;
        case (state_reg)
            B_IDLE: begin
                q_pop = q_valid;
            end
            B_HOUR: begin
                emit      = out_free;
                emit_char = pos_char(rem_cnt_reg - 4'd1, digs_reg);
            end
            B_COLON: begin
                emit      = out_free;
                emit_char = CH_COLON;
            end
            B_MIN: begin
                emit      = out_free;
                emit_char = pos_char(rem_cnt_reg - 4'd1, digs_reg);
                emit_last = (rem_cnt_reg == 4'd1) && !cmd_reg.load;
            end
            B_ACK: begin
                emit      = out_free;
                emit_char = CH_ACK;
                emit_last = 1'b1;
            end
            default: begin
                q_pop = 1'b0;
            end
        endcase
    end

    // Control state and time
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= B_IDLE;
            hour_reg     <= 8'h00;
            min_reg      <= 8'h00;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (q_pop && q_cmd.tick) begin
                hour_reg <= tick_hour;
                min_reg  <= tick_min;
            end else if (state_reg == B_ACK && emit) begin
                hour_reg <= cmd_reg.hour_load;
                min_reg  <= cmd_reg.min_load;
            end
            if (emit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Command, text and output word registers
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cmd_reg     <= q_cmd;
            digs_reg    <= hour_digs;
            rem_cnt_reg <= hour_digs.cnt;
        end else if (state_reg == B_COLON && emit) begin
            digs_reg    <= min_digs;
            rem_cnt_reg <= min_digs.cnt;
        end else if (emit) begin
            rem_cnt_reg <= rem_cnt_reg - 4'd1;
        end
        if (emit) begin
            m_tdata_reg <= emit_char;
            m_tlast_reg <= emit_last;
        end
    end

    `ASSERT_IMP(a_pop_only_idle, aclk, aresetn, q_pop, state_reg == B_IDLE)
    `ASSERT_IMP(a_text_count, aclk, aresetn, state_reg == B_HOUR || state_reg == B_MIN,
                rem_cnt_reg != 4'd0 && rem_cnt_reg <= NEG_TEXT_LEN)
    `ASSERT_NXT(a_ack_loads, aclk, aresetn, state_reg == B_ACK && emit,
                hour_reg == $past(cmd_reg.hour_load) && min_reg == $past(cmd_reg.min_load))
    `ASSERT_NXT(a_colon_to_min, aclk, aresetn, state_reg == B_COLON && emit,
                state_reg == B_MIN && m_tdata == CH_COLON)

endmodule
